// ===== rtl/lbtc_pkg.sv =====
// Shared types and constants for the LRU block tag cache.
`default_nettype none
package lbtc_pkg;

   // Number of cells in the recency chain.
   localparam int ENTRIES = 64;
   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int TAG_W   = 32;
   localparam int TOTAL_W = 32;
   localparam int OSLOT_W = 6;
   localparam int RSP_W   = 104;

   // One cell of the chain: cached address, owned slot and occupancy.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic [TAG_W-1:0]  tag;
   } cell_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/lbtc_cell.sv =====
// One cell of the recency chain: holds an entry, compares it, takes its neighbor's entry.
`default_nettype none
module lbtc_cell (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                shift_en,
   input  wire lbtc_pkg::cell_type                  prev_cell,
   input  wire logic [lbtc_pkg::TAG_W-1:0]          lookup_tag,
   output lbtc_pkg::cell_type                       entry,
   output logic                                     match
);

   logic                          valid_ff;
   logic [lbtc_pkg::SLOT_W-1:0]   slot_ff;
   logic [lbtc_pkg::TAG_W-1:0]    tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= prev_cell.valid;
      end
   end

   // Payload needs no reset; it is only read while valid.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         slot_ff <= prev_cell.slot;
         tag_ff  <= prev_cell.tag;
      end
   end

   assign entry = '{valid: valid_ff, slot: slot_ff, tag: tag_ff};
   assign match = valid_ff && (tag_ff == lookup_tag);

endmodule
`default_nettype wire

// ===== rtl/lru_block_tag_cache.sv =====
// Top level of the fully associative LRU block tag cache built as a chain of cells.
//
//   Channel  Ports                      Direction  Contents
//   request  req_tvalid/tready/tdata    in         lookup_tag [31:0]
//   result   rsp_tvalid/tready/tdata    out        hit, slot, evicted, evicted_tag,
//                                                  hit_total, miss_total
//
// Each request goes through two steps: compare the address against every cell and
// register the match vector, then shift the chain and write the result register.
// A new request is taken in the same cycle that the previous one updates the chain.
// Reset (synchronous, active high) empties every cell and clears the fill count and
// both totals. The update step waits while the result register still holds a result
// that has not been taken; the request side stalls with it.
`default_nettype none
module lru_block_tag_cache (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [31:0]                  req_tdata,   // lookup_tag [31:0]
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // hit [0], slot [6:1], evicted [7], evicted_tag [39:8],
   // hit_total [71:40], miss_total [103:72]
   output logic [lbtc_pkg::RSP_W-1:0]        rsp_tdata
);

   localparam int N = lbtc_pkg::ENTRIES;
   localparam int SW = lbtc_pkg::SLOT_W;

   lbtc_pkg::state_type state_ff, state_in;

   logic [lbtc_pkg::TAG_W-1:0]    lookup_ff;
   logic [N-1:0]                  match;
   logic [N-1:0]                  match_ff;
   logic [N-1:0]                  at_or_after;
   logic [N-1:0]                  shift_en;
   lbtc_pkg::cell_type            cells [N];
   lbtc_pkg::cell_type            prev_cells [N];
   lbtc_pkg::cell_type            new_entry;
   logic [lbtc_pkg::CNT_W-1:0]    fill_ff;
   logic [lbtc_pkg::TOTAL_W-1:0]  hit_cnt_ff, miss_cnt_ff;
   logic [lbtc_pkg::TOTAL_W-1:0]  hit_cnt_in, miss_cnt_in;
   logic                          rsp_valid_ff;
   logic [lbtc_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          update;
   logic                          hit;
   logic                          full;
   logic [SW-1:0]                 hit_slot;
   logic [SW-1:0]                 new_slot;
   logic [lbtc_pkg::TAG_W-1:0]    evict_tag;
   logic [SW+lbtc_pkg::OSLOT_W-1:0] slot_wide;

   // ---------------------------------------------------------------- control
   // The result register frees up when empty or when its result is taken.
   always_comb begin
      update     = (state_ff == lbtc_pkg::ST_UPDATE) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lbtc_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lbtc_pkg::ST_MATCH;
         end
         lbtc_pkg::ST_MATCH: begin
            state_in = lbtc_pkg::ST_UPDATE;
         end
         lbtc_pkg::ST_UPDATE: begin
            if (update) begin
               state_in = req_tvalid ? lbtc_pkg::ST_MATCH : lbtc_pkg::ST_IDLE;
            end
         end
         default: state_in = lbtc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         lbtc_pkg::ST_IDLE:   req_tready = 1'b1;
         lbtc_pkg::ST_UPDATE: req_tready = update;
         default:             req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbtc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lookup_ff <= req_tdata;
      end
   end

   // Compare results are registered so the chain update sees a short path.
   always_ff @(posedge clock) begin
      if (state_ff == lbtc_pkg::ST_MATCH) begin
         match_ff <= match;
      end
   end

   // ------------------------------------------------------------ update step
   // Tags in valid cells are unique, so at most one match bit is set.
   always_comb begin
      hit      = |match_ff;
      hit_slot = '0;
      for (int k = 0; k < N; k++) begin
         hit_slot = hit_slot | ({SW{match_ff[k]}} & cells[k].slot);
      end
   end

   // Marks the hit cell and every cell ahead of it toward cell 0: those cells move on by one.
   always_comb begin
      at_or_after = match_ff;
      for (int l = 0; l < SW; l++) begin
         at_or_after = at_or_after | (at_or_after >> (1 << l));
      end
   end

   assign full = (fill_ff == lbtc_pkg::CNT_W'(N));

   // A miss shifts the whole chain: the first free cell fills from its neighbor,
   // or, when full, the last cell drops out as the eviction.
   always_comb begin
      if (hit) begin
         new_slot = hit_slot;
      end else if (full) begin
         new_slot = cells[N-1].slot;
      end else begin
         new_slot = fill_ff[SW-1:0];
      end
      evict_tag       = (!hit && full) ? cells[N-1].tag : '0;
      new_entry.valid = 1'b1;
      new_entry.slot  = new_slot;
      new_entry.tag   = lookup_ff;
      shift_en        = {N{update}} & (hit ? at_or_after : {N{1'b1}});
   end

   always_comb begin
      prev_cells[0] = new_entry;
      for (int k = 1; k < N; k++) begin
         prev_cells[k] = cells[k-1];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      lbtc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en[g]),
         .prev_cell  (prev_cells[g]),
         .lookup_tag (lookup_ff),
         .entry      (cells[g]),
         .match      (match[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (update && !hit && !full) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // --------------------------------------------------------------- results
   always_comb begin
      hit_cnt_in  = hit_cnt_ff + (hit ? 32'd1 : 32'd0);
      miss_cnt_in = miss_cnt_ff + (hit ? 32'd0 : 32'd1);
      slot_wide   = {{lbtc_pkg::OSLOT_W{1'b0}}, new_slot};
      rsp_data_in = {miss_cnt_in, hit_cnt_in, evict_tag, (!hit && full),
                     slot_wide[lbtc_pkg::OSLOT_W-1:0], hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (update) begin
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== dv/lru_block_tag_cache_tb.sv =====
// Self-checking stream testbench for the LRU block tag cache.
module lru_block_tag_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any request or result taken before the run is declared hung.
   localparam int IDLE_LIMIT  = 3000;
   // Cycles allowed after the last result so a stray extra result would show up.
   localparam int SETTLE_CYC  = 12;
   localparam int LOOKUP_GOAL = 2000;

   // Result word as it travels on rsp_tdata; the last member sits in the lowest bits.
   typedef struct packed {
      logic [lbtc_pkg::TOTAL_W-1:0] miss_total;
      logic [lbtc_pkg::TOTAL_W-1:0] hit_total;
      logic [lbtc_pkg::TAG_W-1:0]   evicted_tag;
      logic                         evicted;
      logic [lbtc_pkg::OSLOT_W-1:0] slot;
      logic                         hit;
   } lookup_result_type;

   // One entry of the stimulus queue. A drain entry sends nothing; it holds the
   // request side idle until every outstanding result has been taken.
   typedef struct {
      bit                         drain;
      logic [lbtc_pkg::TAG_W-1:0] tag;
   } lookup_item_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [lbtc_pkg::TAG_W-1:0]     req_tdata  = '0;      // lookup_tag [31:0]
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // hit [0], slot [6:1], evicted [7], evicted_tag [39:8],
   // hit_total [71:40], miss_total [103:72]
   logic [lbtc_pkg::RSP_W-1:0]     rsp_tdata;

   lru_block_tag_cache u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: the cached tags in recency order, position 0 being the
   // most recently used, each with the slot it owns.
   // ------------------------------------------------------------------------
   logic [lbtc_pkg::TAG_W-1:0]   lru_tag  [0:lbtc_pkg::ENTRIES-1];
   int                           lru_slot [0:lbtc_pkg::ENTRIES-1];
   int                           lru_fill   = 0;
   logic [lbtc_pkg::TOTAL_W-1:0] hit_count  = '0;
   logic [lbtc_pkg::TOTAL_W-1:0] miss_count = '0;

   lookup_item_type    lookup_pending_q[$];
   lookup_result_type  lookup_expect_q[$];
   lookup_result_type  seen_rsp;
   lookup_result_type  want_rsp;
   logic               req_accepted = 1'b0;
   int                 fail_count   = 0;

   // Looks the tag up in the recency list, updates the list and the totals the
   // way the cache does, and returns the result the cache should send back.
   function automatic lookup_result_type predict_lookup(
         input logic [lbtc_pkg::TAG_W-1:0] tag);
      lookup_result_type r;
      int pos;
      int owner;
      int k;
      r   = '0;
      pos = -1;
      for (k = 0; k < lru_fill; k++) begin
         if (pos < 0 && lru_tag[k] == tag) begin
            pos = k;
         end
      end
      if (pos >= 0) begin
         // Hit: the entry keeps its slot and moves to the front.
         r.hit     = 1'b1;
         owner     = lru_slot[pos];
         hit_count = hit_count + 1'b1;
      end else if (lru_fill < lbtc_pkg::ENTRIES) begin
         // Miss with room left: slots are handed out in order from zero.
         pos        = lru_fill;
         owner      = lru_fill;
         lru_fill   = lru_fill + 1;
         miss_count = miss_count + 1'b1;
      end else begin
         // Miss on a full cache: the least recently used entry gives up its slot.
         pos           = lbtc_pkg::ENTRIES - 1;
         owner         = lru_slot[pos];
         r.evicted     = 1'b1;
         r.evicted_tag = lru_tag[pos];
         miss_count    = miss_count + 1'b1;
      end
      for (k = pos; k > 0; k--) begin
         lru_tag[k]  = lru_tag[k-1];
         lru_slot[k] = lru_slot[k-1];
      end
      lru_tag[0]   = tag;
      lru_slot[0]  = owner;
      // Only the low six bits of the slot number leave the block.
      r.slot       = owner[lbtc_pkg::OSLOT_W-1:0];
      r.hit_total  = hit_count;
      r.miss_total = miss_count;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic queue_lookup(input logic [lbtc_pkg::TAG_W-1:0] tag);
      lookup_item_type it;
      it.drain = 1'b0;
      it.tag   = tag;
      lookup_pending_q.push_back(it);
   endtask

   task automatic queue_drain();
      lookup_item_type it;
      it.drain = 1'b1;
      it.tag   = '0;
      lookup_pending_q.push_back(it);
   endtask

   // ------------------------------------------------------------------------
   // Request driver. It works in bursts of random length separated by random
   // gaps; some gaps are zero so there are stretches of back-to-back requests.
   // A request stays on the bus until the cache takes it.
   // ------------------------------------------------------------------------
   int              burst_left = 8;
   int              gap_left   = 0;
   lookup_item_type next_item;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (lookup_pending_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (lookup_pending_q[0].drain) begin
            // Hold off until the bus is quiet and every result is back.
            req_tvalid <= 1'b0;
            if (!req_tvalid && lookup_expect_q.size() == 0) begin
               void'(lookup_pending_q.pop_front());
            end
         end else begin
            next_item = lookup_pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.tag;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver. It moves between stall behaviors chosen at random: always
   // ready, short random stalls, or long stalls, so back-pressure holds the
   // update step of the cache while a result waits to be taken.
   // ------------------------------------------------------------------------
   int rx_cycle   = 0;
   int rx_mode    = 0;
   int stall_left = 0;

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) begin
         rx_mode = $urandom_range(0, 2);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rx_mode == 1 && $urandom_range(0, 99) < 35) begin
            stall_left = $urandom_range(1, 4);
         end else if (rx_mode == 2 && $urandom_range(0, 99) < 15) begin
            stall_left = $urandom_range(5, 25);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Results are checked before the request taken at the same edge
   // is predicted, since a result can never belong to a request taken at the
   // same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp = lookup_result_type'(rsp_tdata);
            if (lookup_expect_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], '0);
            end else begin
               want_rsp = lookup_expect_q.pop_front();
               if (seen_rsp.hit !== want_rsp.hit)
                  report_mismatch("hit", seen_rsp.hit, want_rsp.hit);
               if (seen_rsp.slot !== want_rsp.slot)
                  report_mismatch("slot", seen_rsp.slot, want_rsp.slot);
               if (seen_rsp.evicted !== want_rsp.evicted)
                  report_mismatch("evicted", seen_rsp.evicted, want_rsp.evicted);
               if (seen_rsp.evicted_tag !== want_rsp.evicted_tag)
                  report_mismatch("evicted_tag", seen_rsp.evicted_tag, want_rsp.evicted_tag);
               if (seen_rsp.hit_total !== want_rsp.hit_total)
                  report_mismatch("hit_total", seen_rsp.hit_total, want_rsp.hit_total);
               if (seen_rsp.miss_total !== want_rsp.miss_total)
                  report_mismatch("miss_total", seen_rsp.miss_total, want_rsp.miss_total);
            end
         end
         if (req_tvalid && req_tready) begin
            lookup_expect_q.push_back(predict_lookup(req_tdata));
         end
      end
   end

   // Watchdog: the run is hung if neither side moves for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------------
   initial begin
      logic [lbtc_pkg::TAG_W-1:0] pool [0:127];
      logic [lbtc_pkg::TAG_W-1:0] base;
      logic [lbtc_pkg::TAG_W-1:0] tag;
      int                         pool_n;
      int                         run_len;
      int                         produced;
      int                         roll;
      int                         k;
      bit                         sweep;

      // Directed part: extreme addresses, single-bit and alternating patterns,
      // hits on the most recent and on older entries, all while the cache has
      // room so that nothing is evicted yet.
      queue_lookup(32'h0000_0000);
      queue_lookup(32'hFFFF_FFFF);
      queue_lookup(32'h0000_0000);
      queue_lookup(32'h0000_0000);
      queue_lookup(32'hAAAA_AAAA);
      queue_lookup(32'h5555_5555);
      queue_lookup(32'hFFFF_FFFF);
      queue_lookup(32'h8000_0000);
      queue_lookup(32'h0000_0001);
      queue_lookup(32'hAAAA_AAAA);
      queue_lookup(32'h7FFF_FFFF);
      queue_lookup(32'hFFFF_FFFE);
      queue_lookup(32'h0000_0000);
      queue_drain();

      // Random part, in runs over a working set of addresses. Working sets
      // smaller than the cache mostly hit, sets just at or above its size make
      // the replacement order matter, and larger ones force steady eviction.
      // Sweeps in order over a set one larger than the cache miss every time.
      produced = 0;
      while (produced < LOOKUP_GOAL) begin
         case ($urandom_range(0, 5))
            0: begin
               pool_n = $urandom_range(2, 16);
            end
            1: begin
               pool_n = $urandom_range(17, lbtc_pkg::ENTRIES - 1);
            end
            2: begin
               pool_n = lbtc_pkg::ENTRIES;
            end
            3: begin
               pool_n = lbtc_pkg::ENTRIES + 1;
            end
            default: begin
               pool_n = $urandom_range(lbtc_pkg::ENTRIES + 2, 120);
            end
         endcase
         // Some addresses in each set are one bit away from a shared base, to stress the tag compare.
         base = $urandom;
         for (k = 0; k < pool_n; k++) begin
            if ($urandom_range(0, 1) == 1) begin
               pool[k] = base ^ (32'h1 << $urandom_range(0, 31));
            end else begin
               pool[k] = $urandom;
            end
         end
         sweep   = ($urandom_range(0, 2) == 0);
         run_len = $urandom_range(40, 160);
         for (k = 0; k < run_len; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               tag = $urandom;
            end else if (roll < 11) begin
               tag = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end else if (sweep) begin
               tag = pool[k % pool_n];
            end else begin
               tag = pool[$urandom_range(0, pool_n - 1)];
            end
            queue_lookup(tag);
         end
         produced += run_len;
         if ($urandom_range(0, 3) == 0) begin
            queue_drain();
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every result to come back.
      while (lookup_pending_q.size() != 0 || req_tvalid || lookup_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYC) @(posedge clock);

      if (fail_count == 0 && lookup_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
